@@ rtl/hufdec_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hufdec_pkg
// Shared codes, controller states and the result beat type of the Huffman
// table decoder.
// ----------------------------------------------------------------------------
package hufdec_pkg;

  localparam int FUNC_W   = 2;
  localparam int SYM_W    = 7;
  localparam int CNT_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int BITCNT_W = 4;
  localparam int STAT_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUILD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MID_CODE  = 2'd3;

  localparam logic [BITCNT_W-1:0] MAX_BITS = 4'd8;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_NXT,
    ST_INS_RD,
    ST_INS_CMP,
    ST_MERGE,
    ST_REM_RD1,
    ST_REM_TOP,
    ST_REM_RD,
    ST_REM_CMP,
    ST_REM_LAST,
    ST_ROOT_RD,
    ST_ROOT,
    ST_RESULT,
    ST_DEC_RD,
    ST_DEC_EV1,
    ST_DEC_EV2,
    ST_DEC_EMIT,
    ST_DEC_FLUSH
  } state_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol_out;
    logic              has_symbol;
    logic [STAT_W-1:0] status;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/hufdec_out_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hufdec_out_reg
// Result beat register: holds one beat until the sink takes it.
// ----------------------------------------------------------------------------
module hufdec_out_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire hufdec_pkg::res_t               res,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic [hufdec_pkg::SYM_W-1:0]        out_symbol_out,
  output logic                                out_has_symbol,
  output logic [hufdec_pkg::STAT_W-1:0]       out_status,
  output logic                                out_last,
  output logic                                free
);
  import hufdec_pkg::*;

  logic valid_r;
  res_t res_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_symbol_out = res_r.symbol_out;
  assign out_has_symbol = res_r.has_symbol;
  assign out_status     = res_r.status;
  assign out_last       = res_r.last;

endmodule
`default_nettype wire

@@ rtl/huffman_table_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_table_decoder_unit
// Count table, heap-based Huffman tree build and bit-serial tree walk decode.
// Load count: written when accepted. Finish / status beats wait in ST_RESULT
// until the output register is free. Decode byte: one or two node-memory
// reads per bit, plus an emit state per decoded symbol.
// Build: each scanned symbol passes read, evaluate and next states; each heap
// level of an insert or remove takes a read and a compare; one item at a time.
// Reset clears the count table (valid bits), node count, walk and root, and
// empties the heap.
module huffman_table_decoder_unit #(
  parameter int SYMBOLS    = 128,
  parameter int NODES      = 256,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [hufdec_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [hufdec_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic [hufdec_pkg::CNT_W-1:0]     in_count,
  input  wire logic [hufdec_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic [hufdec_pkg::BITCNT_W-1:0]  in_bit_count,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [hufdec_pkg::SYM_W-1:0]          out_symbol_out,
  output logic                                  out_has_symbol,
  output logic [hufdec_pkg::STAT_W-1:0]         out_status,
  output logic                                  out_last
);
  import hufdec_pkg::*;

  localparam int SW  = $clog2(SYMBOLS);
  localparam int NW  = $clog2(NODES);
  localparam int TW  = $clog2(NODES + 1);
  localparam int HW  = $clog2(NODES + 1);
  localparam int HEW = $clog2(NODES + 2);
  localparam int WW  = COUNT_BITS + SW;

  typedef struct packed {
    logic          leaf;
    logic [SW-1:0] sym;
    logic [NW-1:0] left;
    logic [NW-1:0] right;
  } nd_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [WW-1:0] w;
  } hent_t;

  // memories
  logic [COUNT_BITS-1:0] freq_mem [SYMBOLS];
  logic [SYMBOLS-1:0]    freq_vld_r;
  logic [COUNT_BITS-1:0] fq_q_r;
  logic                  fq_v_r;
  nd_t                   node_mem [NODES];
  nd_t                   nd_q_r;
  hent_t                 heap_mem [NODES+1];
  hent_t                 hp_qa_r;
  hent_t                 hp_qb_r;

  // memory controls
  logic                  fq_we;
  logic                  fq_re;
  logic [SW-1:0]         fq_wa;
  logic [SW-1:0]         fq_ra;
  logic [COUNT_BITS-1:0] fq_wd;
  logic                  nd_we;
  logic [NW-1:0]         nd_wa;
  nd_t                   nd_wd;
  logic                  nd_re;
  logic [NW-1:0]         nd_ra;
  logic                  hp_we;
  logic [HW-1:0]         hp_wa;
  hent_t                 hp_wd;
  logic                  hp_rea;
  logic                  hp_reb;
  logic [HW-1:0]         hp_raa;
  logic [HW-1:0]         hp_rab;

  // control state
  state_t                state_r, state_nxt;
  logic [HEW-1:0]        heap_end_r, heap_end_nxt;
  logic [TW-1:0]         node_total_r, node_total_nxt;
  logic [NW-1:0]         walk_r, walk_nxt;
  logic [NW-1:0]         root_r, root_nxt;
  logic                  tree_ready_r, tree_ready_nxt;
  logic [SW-1:0]         scan_r, scan_nxt;
  logic [HEW-1:0]        idx_r, idx_nxt;
  logic                  ins_scan_r, ins_scan_nxt;
  logic                  rem_second_r, rem_second_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [BITCNT_W-1:0]   bit_k_r, bit_k_nxt;
  logic [BITCNT_W-1:0]   bits_r, bits_nxt;

  // payload registers
  hent_t                 ins_r, ins_nxt;
  hent_t                 top_r, top_nxt;
  hent_t                 rem_a_r, rem_a_nxt;
  logic [NW-1:0]         child_r, child_nxt;
  logic [SW-1:0]         emit_sym_r, emit_sym_nxt;
  logic [SW-1:0]         pend_sym_r, pend_sym_nxt;
  logic [BYTE_W-1:0]     data_r, data_nxt;
  logic [STAT_W-1:0]     stat_r, stat_nxt;

  // output
  logic                  push;
  res_t                  res;
  logic                  out_free;

  // derived
  logic                  accept;
  logic [COUNT_BITS-1:0] fq_val;
  logic [HEW:0]          l_w;
  logic [HEW:0]          l1_w;
  logic                  l_in;
  logic                  pick_b;
  logic [HEW-1:0]        par_w;
  logic                  ins_full;
  logic                  node_room;
  logic [NW-1:0]         new_idx;
  logic                  cur_bit;
  logic                  scan_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign fq_val    = fq_v_r ? fq_q_r : '0;
  assign l_w       = {idx_r, 1'b0};
  assign l1_w      = l_w + (HEW+1)'(1);
  assign l_in      = l_w < {1'b0, heap_end_r};
  assign pick_b    = (l1_w < {1'b0, heap_end_r}) && (hp_qb_r.w < hp_qa_r.w);
  assign par_w     = idx_r >> 1;
  assign ins_full  = heap_end_r > HEW'(NODES);
  assign node_room = node_total_r < TW'(NODES);
  assign new_idx   = node_room ? node_total_r[NW-1:0] : '0;
  assign cur_bit   = data_r[3'(3'd7 - bit_k_r[2:0])];
  assign scan_last = (scan_r == SW'(SYMBOLS - 1));

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (fq_we) begin
      freq_mem[fq_wa] <= fq_wd;
    end
    if (fq_re) begin
      fq_q_r <= freq_mem[fq_ra];
      fq_v_r <= freq_vld_r[fq_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_vld_r <= '0;
    end else if (fq_we) begin
      freq_vld_r[fq_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (nd_we) begin
      node_mem[nd_wa] <= nd_wd;
    end
    if (nd_re) begin
      nd_q_r <= node_mem[nd_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      heap_mem[hp_wa] <= hp_wd;
    end
    if (hp_rea) begin
      hp_qa_r <= heap_mem[hp_raa];
    end
    if (hp_reb) begin
      hp_qb_r <= heap_mem[hp_rab];
    end
  end

  // -------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_LOAD:   state_nxt = ST_IDLE;
            FUNC_BUILD:  state_nxt = ST_SCAN_RD;
            FUNC_DECODE: state_nxt = tree_ready_r ? ST_DEC_RD : ST_RESULT;
            FUNC_FINISH: state_nxt = ST_RESULT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (fq_val == '0 || ins_full) begin
          state_nxt = ST_SCAN_NXT;
        end else begin
          state_nxt = ST_INS_RD;
        end
      end
      ST_SCAN_NXT: state_nxt = scan_last ? ST_MERGE : ST_SCAN_RD;
      ST_INS_RD: begin
        if (par_w == '0) begin
          state_nxt = ins_scan_r ? ST_SCAN_NXT : ST_MERGE;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (hp_qa_r.w <= ins_r.w) begin
          state_nxt = ins_scan_r ? ST_SCAN_NXT : ST_MERGE;
        end else begin
          state_nxt = ST_INS_RD;
        end
      end
      ST_MERGE: begin
        if (heap_end_r > HEW'(2)) begin
          state_nxt = ST_REM_RD1;
        end else if (heap_end_r < HEW'(2)) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_ROOT_RD;
        end
      end
      ST_REM_RD1:  state_nxt = ST_REM_TOP;
      ST_REM_TOP:  state_nxt = ST_REM_RD;
      ST_REM_RD:   state_nxt = l_in ? ST_REM_CMP : ST_REM_LAST;
      ST_REM_CMP:  state_nxt = ST_REM_RD;
      ST_REM_LAST: begin
        if (!rem_second_r) begin
          state_nxt = ST_REM_RD1;
        end else if (ins_full) begin
          state_nxt = ST_MERGE;
        end else begin
          state_nxt = ST_INS_RD;
        end
      end
      ST_ROOT_RD:  state_nxt = ST_ROOT;
      ST_ROOT:     state_nxt = ST_RESULT;
      ST_RESULT:   state_nxt = out_free ? ST_IDLE : ST_RESULT;
      ST_DEC_RD:   state_nxt = (bit_k_r == bits_r) ? ST_DEC_FLUSH : ST_DEC_EV1;
      ST_DEC_EV1:  state_nxt = nd_q_r.leaf ? ST_DEC_EMIT : ST_DEC_EV2;
      ST_DEC_EV2:  state_nxt = nd_q_r.leaf ? ST_DEC_EMIT : ST_DEC_RD;
      ST_DEC_EMIT: state_nxt = (pend_v_r && !out_free) ? ST_DEC_EMIT : ST_DEC_RD;
      ST_DEC_FLUSH: begin
        state_nxt = (pend_v_r && !out_free) ? ST_DEC_FLUSH : ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    fq_we          = 1'b0;
    fq_wa          = SW'(in_symbol);
    fq_wd          = COUNT_BITS'(in_count);
    fq_re          = 1'b0;
    fq_ra          = scan_r;
    nd_we          = 1'b0;
    nd_wa          = new_idx;
    nd_wd          = '0;
    nd_re          = 1'b0;
    nd_ra          = walk_r;
    hp_we          = 1'b0;
    hp_wa          = idx_r[HW-1:0];
    hp_wd          = ins_r;
    hp_rea         = 1'b0;
    hp_reb         = 1'b0;
    hp_raa         = par_w[HW-1:0];
    hp_rab         = l1_w[HW-1:0];
    push           = 1'b0;
    res            = '0;
    heap_end_nxt   = heap_end_r;
    node_total_nxt = node_total_r;
    walk_nxt       = walk_r;
    root_nxt       = root_r;
    tree_ready_nxt = tree_ready_r;
    scan_nxt       = scan_r;
    idx_nxt        = idx_r;
    ins_scan_nxt   = ins_scan_r;
    rem_second_nxt = rem_second_r;
    pend_v_nxt     = pend_v_r;
    bit_k_nxt      = bit_k_r;
    bits_nxt       = bits_r;
    ins_nxt        = ins_r;
    top_nxt        = top_r;
    rem_a_nxt      = rem_a_r;
    child_nxt      = child_r;
    emit_sym_nxt   = emit_sym_r;
    pend_sym_nxt   = pend_sym_r;
    data_nxt       = data_r;
    stat_nxt       = stat_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_LOAD: begin
              fq_we          = (32'(in_symbol) < SYMBOLS);
              tree_ready_nxt = 1'b0;
            end
            FUNC_BUILD: begin
              heap_end_nxt   = HEW'(1);
              node_total_nxt = '0;
              scan_nxt       = '0;
            end
            FUNC_DECODE: begin
              stat_nxt  = STAT_NOT_BUILT;
              data_nxt  = in_data_byte;
              bits_nxt  = (in_bit_count > MAX_BITS) ? MAX_BITS : in_bit_count;
              bit_k_nxt = '0;
              pend_v_nxt = 1'b0;
            end
            FUNC_FINISH: begin
              if (!tree_ready_r) begin
                stat_nxt = STAT_NOT_BUILT;
              end else if (walk_r != root_r) begin
                stat_nxt = STAT_MID_CODE;
                walk_nxt = root_r;
              end else begin
                stat_nxt = STAT_OK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        fq_re = 1'b1;
      end
      ST_SCAN_EV: begin
        if (fq_val != '0 && !ins_full) begin
          nd_we          = node_room;
          nd_wd.leaf     = 1'b1;
          nd_wd.sym      = scan_r;
          node_total_nxt = node_room ? node_total_r + TW'(1) : node_total_r;
          ins_nxt.node   = new_idx;
          ins_nxt.w      = WW'(fq_val);
          ins_scan_nxt   = 1'b1;
          idx_nxt        = heap_end_r;
          heap_end_nxt   = heap_end_r + HEW'(1);
        end
      end
      ST_SCAN_NXT: begin
        scan_nxt = scan_r + SW'(1);
      end
      ST_INS_RD: begin
        if (par_w == '0) begin
          hp_we = 1'b1;
        end else begin
          hp_rea = 1'b1;
        end
      end
      ST_INS_CMP: begin
        hp_we = 1'b1;
        if (!(hp_qa_r.w <= ins_r.w)) begin
          hp_wd   = hp_qa_r;
          idx_nxt = par_w;
        end
      end
      ST_MERGE: begin
        rem_second_nxt = 1'b0;
        if (heap_end_r < HEW'(2)) begin
          tree_ready_nxt = 1'b0;
          stat_nxt       = STAT_EMPTY;
        end
      end
      ST_REM_RD1: begin
        hp_rea = 1'b1;
        hp_raa = HW'(1);
      end
      ST_REM_TOP: begin
        top_nxt      = hp_qa_r;
        heap_end_nxt = heap_end_r - HEW'(1);
        idx_nxt      = HEW'(1);
      end
      ST_REM_RD: begin
        hp_rea = 1'b1;
        if (l_in) begin
          hp_raa = l_w[HW-1:0];
          hp_reb = 1'b1;
        end else begin
          hp_raa = heap_end_r[HW-1:0];
        end
      end
      ST_REM_CMP: begin
        hp_we   = 1'b1;
        hp_wd   = pick_b ? hp_qb_r : hp_qa_r;
        idx_nxt = pick_b ? l1_w[HEW-1:0] : l_w[HEW-1:0];
      end
      ST_REM_LAST: begin
        hp_we = 1'b1;
        hp_wd = hp_qa_r;
        if (!rem_second_r) begin
          rem_a_nxt      = top_r;
          rem_second_nxt = 1'b1;
        end else if (!ins_full) begin
          nd_we          = node_room;
          nd_wd.leaf     = 1'b0;
          nd_wd.left     = rem_a_r.node;
          nd_wd.right    = top_r.node;
          node_total_nxt = node_room ? node_total_r + TW'(1) : node_total_r;
          ins_nxt.node   = new_idx;
          ins_nxt.w      = rem_a_r.w + top_r.w;
          ins_scan_nxt   = 1'b0;
          idx_nxt        = heap_end_r;
          heap_end_nxt   = heap_end_r + HEW'(1);
        end
      end
      ST_ROOT_RD: begin
        hp_rea = 1'b1;
        hp_raa = HW'(1);
      end
      ST_ROOT: begin
        root_nxt       = hp_qa_r.node;
        walk_nxt       = hp_qa_r.node;
        tree_ready_nxt = 1'b1;
        stat_nxt       = STAT_OK;
      end
      ST_RESULT: begin
        if (out_free) begin
          push       = 1'b1;
          res.status = stat_r;
          res.last   = 1'b1;
        end
      end
      ST_DEC_RD: begin
        nd_re = (bit_k_r != bits_r);
        nd_ra = walk_r;
      end
      ST_DEC_EV1: begin
        if (nd_q_r.leaf) begin
          emit_sym_nxt = nd_q_r.sym;
        end else begin
          nd_re     = 1'b1;
          nd_ra     = cur_bit ? nd_q_r.right : nd_q_r.left;
          child_nxt = cur_bit ? nd_q_r.right : nd_q_r.left;
        end
      end
      ST_DEC_EV2: begin
        if (nd_q_r.leaf) begin
          emit_sym_nxt = nd_q_r.sym;
        end else begin
          walk_nxt  = child_r;
          bit_k_nxt = bit_k_r + BITCNT_W'(1);
        end
      end
      ST_DEC_EMIT: begin
        if (!(pend_v_r && !out_free)) begin
          push           = pend_v_r;
          res.symbol_out = SYM_W'(pend_sym_r);
          res.has_symbol = 1'b1;
          res.status     = STAT_OK;
          res.last       = 1'b0;
          pend_sym_nxt   = emit_sym_r;
          pend_v_nxt     = 1'b1;
          walk_nxt       = root_r;
          bit_k_nxt      = bit_k_r + BITCNT_W'(1);
        end
      end
      ST_DEC_FLUSH: begin
        if (pend_v_r && out_free) begin
          push           = 1'b1;
          res.symbol_out = SYM_W'(pend_sym_r);
          res.has_symbol = 1'b1;
          res.status     = STAT_OK;
          res.last       = 1'b1;
          pend_v_nxt     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      heap_end_r   <= HEW'(1);
      node_total_r <= '0;
      walk_r       <= '0;
      root_r       <= '0;
      tree_ready_r <= 1'b0;
      scan_r       <= '0;
      idx_r        <= '0;
      ins_scan_r   <= 1'b0;
      rem_second_r <= 1'b0;
      pend_v_r     <= 1'b0;
      bit_k_r      <= '0;
      bits_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      heap_end_r   <= heap_end_nxt;
      node_total_r <= node_total_nxt;
      walk_r       <= walk_nxt;
      root_r       <= root_nxt;
      tree_ready_r <= tree_ready_nxt;
      scan_r       <= scan_nxt;
      idx_r        <= idx_nxt;
      ins_scan_r   <= ins_scan_nxt;
      rem_second_r <= rem_second_nxt;
      pend_v_r     <= pend_v_nxt;
      bit_k_r      <= bit_k_nxt;
      bits_r       <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    top_r      <= top_nxt;
    rem_a_r    <= rem_a_nxt;
    child_r    <= child_nxt;
    emit_sym_r <= emit_sym_nxt;
    pend_sym_r <= pend_sym_nxt;
    data_r     <= data_nxt;
    stat_r     <= stat_nxt;
  end

  hufdec_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .res            (res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_symbol_out (out_symbol_out),
    .out_has_symbol (out_has_symbol),
    .out_status     (out_status),
    .out_last       (out_last),
    .free           (out_free)
  );

`ifndef ASSERT_OFF
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result beat pushed into a full output register");

  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heap_end_r <= HEW'(NODES + 1))
    else $error("heap end beyond heap store");

  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tree_ready_r) |-> $past(state_r) == ST_ROOT)
    else $error("tree marked ready outside root fetch");
`endif

endmodule
`default_nettype wire
